// ===== rtl/brb_pkg.sv =====
// Package: shared constants, types and pointer arithmetic for the byte ring buffer.
`default_nettype none
package brb_pkg;

    localparam int DEPTH   = 1024;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = 10;
    localparam int REQ_W   = 16;
    localparam int IDX_W   = 10;
    localparam int ACT_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 64;
    localparam int ALIGN_W = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE_BEGIN = 3'd0,
        ACT_WRITE_BYTE  = 3'd1,
        ACT_READ_EXACT  = 3'd2,
        ACT_READ_BYTE   = 3'd3,
        ACT_READ_START  = 3'd4,
        ACT_READ_END    = 3'd5,
        ACT_READ_AT     = 3'd6,
        ACT_CLEAR       = 3'd7
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

    function automatic logic [PTR_W:0] free_of(input logic [PTR_W-1:0] rp,
                                               input logic [PTR_W-1:0] wp);
        logic [PTR_W:0] r;
        logic [PTR_W:0] w;
        r = {1'b0, rp};
        w = {1'b0, wp};
        if (wp < rp)
            free_of = r - w - (PTR_W+1)'(1);
        else
            free_of = (PTR_W+1)'(DEPTH) + r - w - (PTR_W+1)'(1);
    endfunction

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        advance = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/brb_ctrl.sv =====
// Controller: sequences each transaction through load, execute and response.
`default_nettype none
module brb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output brb_pkg::ctl_cmd_t      cmd
);

    brb_pkg::state_t state_reg;
    brb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= brb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            brb_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = brb_pkg::ST_EXEC;
                end
            end
            brb_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = brb_pkg::ST_RESP;
            end
            brb_pkg::ST_RESP:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                    state_next = brb_pkg::ST_IDLE;
            end
            default:
                state_next = brb_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/brb_dp.sv =====
// Datapath: pointers, burst counters, byte storage and result registers.
`default_nettype none
module brb_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire brb_pkg::ctl_cmd_t            cmd,
    input  wire logic [brb_pkg::IN_W-1:0]     in_data,
    output logic      [brb_pkg::OUT_W-1:0]    out_data
);

    localparam int PW = brb_pkg::PTR_W;
    localparam int CW = brb_pkg::CNT_W;

    logic [brb_pkg::ACT_W-1:0]  act_reg;
    logic [brb_pkg::BYTE_W-1:0] byte_reg;
    logic [brb_pkg::REQ_W-1:0]  req_reg;
    logic [brb_pkg::IDX_W-1:0]  idx_reg;

    logic [PW-1:0] rp_reg,   rp_next;
    logic [PW-1:0] wp_reg,   wp_next;
    logic [PW-1:0] prp_reg,  prp_next;
    logic [PW-1:0] wrem_reg, wrem_next;
    logic [PW-1:0] rrem_reg, rrem_next;

    logic          ok_reg,    ok_next;
    logic          rsel_reg,  rsel_next;
    logic [PW-1:0] grant_reg, grant_next;
    logic [PW-1:0] coff_reg,  coff_next;
    logic [PW:0]   csize_reg, csize_next;

    logic [brb_pkg::BYTE_W-1:0] mem [brb_pkg::DEPTH];
    logic [brb_pkg::BYTE_W-1:0] rd_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [PW-1:0]              mem_raddr;

    logic [PW:0]   free_cur;
    logic [PW:0]   avail_cur;
    logic [PW:0]   room;
    logic [PW-1:0] idx_p;
    logic [PW-1:0] len;
    logic [PW-1:0] pos_off;
    logic [PW:0]   free_out;
    logic [PW:0]   avail_out;
    logic [brb_pkg::BYTE_W-1:0] rdata_out;

    assign idx_p     = PW'(idx_reg);
    assign free_cur  = brb_pkg::free_of(rp_reg, wp_reg);
    assign avail_cur = (PW+1)'(brb_pkg::DEPTH - 1) - free_cur;
    assign room      = {free_cur[PW:brb_pkg::ALIGN_W], {brb_pkg::ALIGN_W{1'b0}}};
    assign len       = prp_reg - rp_reg;
    assign pos_off   = idx_p - rp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= in_data[2:0];
            byte_reg <= in_data[10:3];
            req_reg  <= in_data[26:11];
            idx_reg  <= in_data[36:27];
        end
        if (cmd.exec)
        begin
            grant_reg <= grant_next;
            coff_reg  <= coff_next;
            csize_reg <= csize_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= byte_reg;
        if (mem_re)
            rd_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg   <= '0;
            wp_reg   <= '0;
            prp_reg  <= '0;
            wrem_reg <= '0;
            rrem_reg <= '0;
            ok_reg   <= 1'b0;
            rsel_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            rp_reg   <= rp_next;
            wp_reg   <= wp_next;
            prp_reg  <= prp_next;
            wrem_reg <= wrem_next;
            rrem_reg <= rrem_next;
            ok_reg   <= ok_next;
            rsel_reg <= rsel_next;
        end
    end

    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        prp_next   = prp_reg;
        wrem_next  = wrem_reg;
        rrem_next  = rrem_reg;
        ok_next    = 1'b0;
        rsel_next  = 1'b0;
        grant_next = '0;
        coff_next  = '0;
        csize_next = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = rp_reg;
        unique case (brb_pkg::act_t'(act_reg))
            brb_pkg::ACT_WRITE_BEGIN:
            begin
                if ({1'b0, req_reg} < (brb_pkg::REQ_W+1)'(room))
                    grant_next = PW'(req_reg);
                else
                    grant_next = room[PW-1:0];
                wrem_next = grant_next;
                ok_next   = (grant_next != '0);
            end
            brb_pkg::ACT_WRITE_BYTE:
            begin
                if (wrem_reg != '0 && free_cur != '0)
                begin
                    mem_we    = cmd.exec;
                    wp_next   = brb_pkg::advance(wp_reg);
                    wrem_next = wrem_reg - PW'(1);
                    ok_next   = 1'b1;
                end
            end
            brb_pkg::ACT_READ_EXACT:
            begin
                if ({1'b0, req_reg} > (brb_pkg::REQ_W+1)'(avail_cur))
                    rrem_next = '0;
                else
                begin
                    rrem_next = PW'(req_reg);
                    ok_next   = 1'b1;
                end
            end
            brb_pkg::ACT_READ_BYTE:
            begin
                if (rrem_reg != '0 && rp_reg != wp_reg)
                begin
                    mem_re    = cmd.exec;
                    rsel_next = 1'b1;
                    rp_next   = brb_pkg::advance(rp_reg);
                    rrem_next = rrem_reg - PW'(1);
                    ok_next   = 1'b1;
                end
            end
            brb_pkg::ACT_READ_START:
            begin
                coff_next = rp_reg;
                if (wp_reg == rp_reg)
                    prp_next = rp_reg;
                else if (wp_reg < rp_reg)
                begin
                    csize_next = (PW+1)'(brb_pkg::DEPTH) - {1'b0, rp_reg};
                    prp_next   = '0;
                    ok_next    = 1'b1;
                end
                else
                begin
                    csize_next = {1'b0, wp_reg - rp_reg};
                    prp_next   = wp_reg;
                    ok_next    = 1'b1;
                end
            end
            brb_pkg::ACT_READ_END:
            begin
                rp_next = prp_reg;
                ok_next = 1'b1;
            end
            brb_pkg::ACT_READ_AT:
            begin
                mem_re    = cmd.exec;
                mem_raddr = idx_p;
                rsel_next = 1'b1;
                ok_next   = (pos_off < len);
            end
            brb_pkg::ACT_CLEAR:
            begin
                rp_next   = wp_reg;
                prp_next  = wp_reg;
                rrem_next = '0;
                ok_next   = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign free_out  = brb_pkg::free_of(rp_reg, wp_reg);
    assign avail_out = (PW+1)'(brb_pkg::DEPTH - 1) - free_out;
    assign rdata_out = rsel_reg ? rd_reg : '0;

    assign out_data = {5'd0,
                       CW'(avail_out),
                       CW'(free_out),
                       CW'(csize_reg),
                       CW'(coff_reg),
                       CW'(grant_reg),
                       rdata_out,
                       ok_reg};

endmodule
`default_nettype wire

// ===== rtl/byte_ring_buffer_pipe_top.sv =====
// Top level: byte ring buffer with stream ports, controller and datapath.
// A transaction is loaded when accepted in the idle state, then executed; its result
// is presented in the response state, and no new transaction is accepted until the
// response is taken. The controller runs load, execute and response in turn, the
// response waiting on the registered storage read port.
// Reset: asynchronous, active low; pointers and counters clear, storage is left as is.
`default_nettype none
module byte_ring_buffer_pipe_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // action[2:0], data_byte[10:3], request_count[26:11], chunk_index[36:27], zero pad
    input  wire logic [brb_pkg::IN_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // ok[0], read_data[8:1], granted_count[18:9], chunk_offset[28:19],
    // chunk_size[38:29], free_space[48:39], available_bytes[58:49], zero pad
    output logic      [brb_pkg::OUT_W-1:0]     m_tdata
);

    brb_pkg::ctl_cmd_t cmd;

    brb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    brb_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule
`default_nettype wire

// ===== tb/byte_ring_buffer_pipe_top_test.sv =====
`timescale 1ns / 100ps
// Testbench for the byte ring buffer: command streams with random gaps checked against a predictor.

class ring_reply_board;
    typedef struct {
        bit       ok;
        bit [7:0] data;
        bit [9:0] grant;
        bit [9:0] offset;
        bit [9:0] size;
        bit [9:0] free;
        bit [9:0] held;
    } reply_t;

    bit [7:0]    mem [brb_pkg::DEPTH];
    bit          written [brb_pkg::DEPTH];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    int unsigned pend_ptr;
    int unsigned wr_left;
    int unsigned rd_left;
    int unsigned last_stored;
    reply_t      replies_due [$];
    int          errors;

    function int unsigned room_left();
        if (wr_ptr < rd_ptr)
            return rd_ptr - wr_ptr - 1;
        return brb_pkg::DEPTH + rd_ptr - wr_ptr - 1;
    endfunction

    function int unsigned bytes_held();
        return brb_pkg::DEPTH - 1 - room_left();
    endfunction

    function int unsigned next_pos(int unsigned p);
        return (p + 1) % brb_pkg::DEPTH;
    endfunction

    function void accept_command(brb_pkg::act_t op, bit [7:0] din, bit [15:0] req,
                                 bit [9:0] pos);
        reply_t      r;
        int unsigned span;
        r = '{default: 0};
        case (op)
            brb_pkg::ACT_WRITE_BEGIN:
            begin
                span = room_left() & ~32'd7;
                wr_left = (req < span) ? req : span;
                r.grant = 10'(wr_left);
                r.ok = wr_left != 0;
            end
            brb_pkg::ACT_WRITE_BYTE:
            begin
                if (wr_left != 0 && room_left() != 0)
                begin
                    mem[wr_ptr] = din;
                    written[wr_ptr] = 1'b1;
                    last_stored = wr_ptr;
                    wr_ptr = next_pos(wr_ptr);
                    wr_left--;
                    r.ok = 1'b1;
                end
            end
            brb_pkg::ACT_READ_EXACT:
            begin
                if (req > bytes_held())
                    rd_left = 0;
                else
                begin
                    rd_left = req;
                    r.ok = 1'b1;
                end
            end
            brb_pkg::ACT_READ_BYTE:
            begin
                if (rd_left != 0 && rd_ptr != wr_ptr)
                begin
                    r.data = mem[rd_ptr];
                    rd_ptr = next_pos(rd_ptr);
                    rd_left--;
                    r.ok = 1'b1;
                end
            end
            brb_pkg::ACT_READ_START:
            begin
                r.offset = 10'(rd_ptr);
                if (wr_ptr == rd_ptr)
                    pend_ptr = rd_ptr;
                else if (wr_ptr < rd_ptr)
                begin
                    r.size = 10'(brb_pkg::DEPTH - rd_ptr);
                    pend_ptr = 0;
                    r.ok = 1'b1;
                end
                else
                begin
                    r.size = 10'(wr_ptr - rd_ptr);
                    pend_ptr = wr_ptr;
                    r.ok = 1'b1;
                end
            end
            brb_pkg::ACT_READ_END:
            begin
                rd_ptr = pend_ptr;
                r.ok = 1'b1;
            end
            brb_pkg::ACT_READ_AT:
            begin
                span = (pend_ptr + brb_pkg::DEPTH - rd_ptr) % brb_pkg::DEPTH;
                r.data = mem[pos];
                r.ok = ((pos + brb_pkg::DEPTH - rd_ptr) % brb_pkg::DEPTH) < span;
            end
            default:
            begin
                rd_ptr = wr_ptr;
                pend_ptr = wr_ptr;
                rd_left = 0;
                r.ok = 1'b1;
            end
        endcase
        r.free = 10'(room_left());
        r.held = 10'(bytes_held());
        replies_due.push_back(r);
    endfunction

    function void compare(string field, bit [9:0] want, logic [9:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_reply(logic [brb_pkg::OUT_W-1:0] w);
        reply_t e;
        if (replies_due.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, w);
            errors++;
            return;
        end
        e = replies_due.pop_front();
        compare("ok", 10'(e.ok), 10'(w[0]));
        compare("read_data", 10'(e.data), 10'(w[8:1]));
        compare("granted_count", e.grant, w[18:9]);
        compare("chunk_offset", e.offset, w[28:19]);
        compare("chunk_size", e.size, w[38:29]);
        compare("free_space", e.free, w[48:39]);
        compare("available_bytes", e.held, w[58:49]);
    endfunction
endclass

module byte_ring_buffer_pipe_top_test;
    import brb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tready = 1'b0;
    wire               s_tready;
    wire               m_tvalid;
    wire  [OUT_W-1:0]  m_tdata;

    ring_reply_board   board = new;
    bit                steady;
    int unsigned       sent;
    int unsigned       taken;
    int unsigned       cycles;

    byte_ring_buffer_pipe_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic issue(act_t op, bit [7:0] din = '0, bit [15:0] req = '0,
                         bit [9:0] pos = '0);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, pos, req, din, op};
        do @(posedge clk); while (!s_tready);
        board.accept_command(op, din, req, pos);
        sent++;
    endtask

    function automatic bit [9:0] stored_position();
        bit [9:0] p;
        p = 10'($urandom_range(0, DEPTH - 1));
        if (!board.written[p])
            p = 10'(board.last_stored);
        return p;
    endfunction

    initial
    begin
        bit [7:0]    corner_bytes [6] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0};
        int unsigned kind;
        int unsigned k;
        int unsigned n;
        int unsigned held;
        int unsigned chunk;
        act_t        op;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        issue(ACT_READ_START);
        issue(ACT_READ_BYTE);
        issue(ACT_WRITE_BYTE, 8'hFF);
        issue(ACT_READ_EXACT, '0, 16'd0);
        issue(ACT_READ_EXACT, '0, 16'hFFFF);
        issue(ACT_WRITE_BEGIN, '0, 16'd0);
        issue(ACT_WRITE_BEGIN, '0, 16'hFFFF);
        issue(ACT_WRITE_BEGIN, '0, 16'd6);
        foreach (corner_bytes[i])
            issue(ACT_WRITE_BYTE, corner_bytes[i]);
        issue(ACT_WRITE_BYTE, 8'h5A);
        issue(ACT_READ_AT, '0, '0, 10'd3);
        issue(ACT_READ_EXACT, '0, 16'd2);
        repeat (3) issue(ACT_READ_BYTE);
        issue(ACT_READ_START);
        issue(ACT_READ_AT, '0, '0, 10'd0);
        issue(ACT_READ_AT, '0, '0, 10'd5);
        issue(ACT_READ_END);
        issue(ACT_WRITE_BEGIN, '0, 16'd3);
        issue(ACT_CLEAR);
        issue(ACT_WRITE_BYTE, 8'h81);

        while (sent < 1750)
        begin
            if ($urandom_range(0, 19) == 0)
                steady = !steady;
            kind = $urandom_range(0, 99);
            held = board.bytes_held();
            if (kind < 35)
            begin
                k = $urandom_range(0, 99);
                n = (k < 70) ? $urandom_range(1, 48) :
                    (k < 92) ? $urandom_range(49, 300) :
                    (k < 97) ? $urandom_range(301, 1023) : $urandom_range(0, 65535);
                issue(ACT_WRITE_BEGIN, 8'($urandom), 16'(n), 10'($urandom));
                n = board.wr_left;
                k = $urandom_range(0, 9);
                if (k == 0)
                    n += $urandom_range(1, 3);
                else if (k == 1)
                    n = $urandom_range(0, n);
                repeat (n)
                    issue(ACT_WRITE_BYTE, 8'($urandom), 16'($urandom), 10'($urandom));
            end
            else if (kind < 60)
            begin
                k = $urandom_range(0, 9);
                n = (k < 8) ? $urandom_range(0, (held < 40) ? held : 40) :
                    (k == 8) ? held + $urandom_range(1, 20) : $urandom_range(0, 65535);
                issue(ACT_READ_EXACT, 8'($urandom), 16'(n), 10'($urandom));
                n = board.rd_left;
                k = $urandom_range(0, 9);
                if (k == 0)
                    n += $urandom_range(1, 3);
                else if (k == 1)
                    n = $urandom_range(0, n);
                repeat (n)
                    issue(ACT_READ_BYTE, 8'($urandom), 16'($urandom), 10'($urandom));
            end
            else if (kind < 85)
            begin
                issue(ACT_READ_START, 8'($urandom), 16'($urandom), 10'($urandom));
                chunk = (board.pend_ptr + DEPTH - board.rd_ptr) % DEPTH;
                repeat ($urandom_range(0, 4))
                    issue(ACT_READ_AT, 8'($urandom), 16'($urandom),
                          (chunk != 0 && $urandom_range(0, 3) != 0) ?
                          10'((board.rd_ptr + $urandom_range(0, chunk - 1)) % DEPTH) :
                          stored_position());
                if ($urandom_range(0, 9) != 0)
                    issue(ACT_READ_END, 8'($urandom), 16'($urandom), 10'($urandom));
            end
            else if (kind < 90)
                issue(ACT_CLEAR, 8'($urandom), 16'($urandom), 10'($urandom));
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    op = act_t'($urandom_range(0, 7));
                    issue(op, 8'($urandom), 16'($urandom),
                          (op == ACT_READ_AT) ? stored_position() : 10'($urandom));
                end
            end
        end
        s_tvalid <= 1'b0;

        while (board.replies_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("byte_ring_buffer_pipe_top_test passed");
        else
            $display("byte_ring_buffer_pipe_top_test failed");
        $finish;
    end

    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 13);
            if (taken == 300 || taken == 1100)
                stall = 400;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_reply(m_tdata);
            taken++;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk) cycles++;
        $display("byte_ring_buffer_pipe_top_test failed");
        $finish;
    end

endmodule
